// ----- rtl/octree_cell_index_from_box_core_assert.svh -----
// assertion macros for the octree cell index block
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef OCTREE_CELL_INDEX_FROM_BOX_CORE_ASSERT_SVH
`define OCTREE_CELL_INDEX_FROM_BOX_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define OCI_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("octree cell index: implication check failed");
// next-cycle implication
`define OCI_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("octree cell index: next-cycle check failed");
`else
`define OCI_ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define OCI_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ----- rtl/oci_pkg.sv -----
// types, constants and helpers for the octree cell index block
// no dependencies
package oci_pkg;

    localparam int COORD_W         = 32;
    localparam int FRAC_W          = 16;
    localparam int TREE_LEVELS_DEF = 3;
    localparam int MAX_LEVELS      = 10;
    localparam int INDEX_W         = 10;
    localparam int LEVEL_W         = 2;
    localparam int CFG_IDX_W       = 1;

    localparam logic signed [COORD_W-1:0] TREE_ORIGIN_RST = -32'sd3276800;
    localparam logic [COORD_W-1:0]        CELL_SCALE_RST  = 32'd5243;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TREE_ORIGIN = 1'b0,
        CFG_CELL_SCALE  = 1'b1
    } cfg_reg_e;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
    } box_t;

    typedef struct packed {
        logic [INDEX_W-1:0] cell_index;
        logic [LEVEL_W-1:0] cell_level;
        logic               out_of_range;
    } cell_t;

    // first linear index of a level: (8^lvl - 1) / 7
    function automatic logic [31:0] level_offset(input int unsigned lvl);
        logic [31:0] acc;
        acc = '0;
        for (int k = 0; k < MAX_LEVELS; k++) begin
            if (k < lvl) begin
                acc = {acc[28:0], 3'b000} | 32'd1;
            end
        end
        return acc;
    endfunction

endpackage

// ----- rtl/octree_cell_index_from_box_core.sv -----
// octree cell index of an axis-aligned box, four-stage pipeline
// depends on oci_pkg and octree_cell_index_from_box_core_assert.svh
// throughput: one item per cycle; busy stays low, done is a one-cycle strobe
// the slowest stage is the 17x32 / 16x32 partial products of each coordinate
// reset: clears the stage valids and loads tree_origin -50.0, cell_scale 5243
`include "octree_cell_index_from_box_core_assert.svh"

module octree_cell_index_from_box_core #(
    parameter int TREE_LEVELS = oci_pkg::TREE_LEVELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // item in
    input  logic                          start,
    output logic                          busy,
    input  oci_pkg::box_t                 box,
    // item out
    output logic                          done,
    output oci_pkg::cell_t                result,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [oci_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [oci_pkg::COORD_W-1:0]   cfg_data
);

    localparam int NCOORD = 6;
    localparam int CODE_W = 3 * TREE_LEVELS;        // morton code width
    localparam int CALC_W = CODE_W + 1;             // index before masking
    localparam int LVL_W  = $clog2(TREE_LEVELS + 1);
    localparam int DIFF_W = oci_pkg::COORD_W + 2;   // exact pos - origin
    localparam int UD_W   = oci_pkg::COORD_W + 1;   // non-negative part
    localparam int HI_W   = UD_W - oci_pkg::FRAC_W;
    localparam int HP_W   = HI_W + oci_pkg::COORD_W;
    localparam int SUM_W  = HP_W + 1;
    localparam int C_W    = SUM_W - oci_pkg::FRAC_W;

    // ---------------- configuration registers ----------------
    logic signed [oci_pkg::COORD_W-1:0] origin_reg;
    logic        [oci_pkg::COORD_W-1:0] scale_reg;

    // no backpressure anywhere: writes land at once
    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            origin_reg <= oci_pkg::TREE_ORIGIN_RST;
            scale_reg  <= oci_pkg::CELL_SCALE_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (oci_pkg::cfg_reg_e'(cfg_index))
                oci_pkg::CFG_TREE_ORIGIN: origin_reg <= cfg_data;
                oci_pkg::CFG_CELL_SCALE:  scale_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage 1: input register ----------------
    logic          s1_vld_reg;
    oci_pkg::box_t box_s1_reg;
    logic signed [oci_pkg::COORD_W-1:0] pos_s1 [NCOORD];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk) begin
        if (start && !busy) begin
            box_s1_reg <= box;
        end
    end

    // order matters: min corner first, x y z within a corner
    assign pos_s1[0] = box_s1_reg.min_x;
    assign pos_s1[1] = box_s1_reg.min_y;
    assign pos_s1[2] = box_s1_reg.min_z;
    assign pos_s1[3] = box_s1_reg.max_x;
    assign pos_s1[4] = box_s1_reg.max_y;
    assign pos_s1[5] = box_s1_reg.max_z;

    // ---------------- stage 2: offset from tree origin ----------------
    logic                s2_vld_reg;
    logic [NCOORD-1:0]   neg_s2_next, neg_s2_reg;
    logic [UD_W-1:0]     ud_s2_next [NCOORD];
    logic [UD_W-1:0]     ud_s2_reg  [NCOORD];

    always_comb begin
        logic [DIFF_W-1:0] d;
        for (int i = 0; i < NCOORD; i++) begin
            d = {{2{pos_s1[i][oci_pkg::COORD_W-1]}}, pos_s1[i]}
              - {{2{origin_reg[oci_pkg::COORD_W-1]}}, origin_reg};
            neg_s2_next[i] = d[DIFF_W-1];
            ud_s2_next[i]  = d[UD_W-1:0];
        end
    end

    // ---------------- stage 3: partial products ----------------
    logic                          s3_vld_reg;
    logic [NCOORD-1:0]             neg_s3_reg;
    logic [HP_W-1:0]               hp_s3_next [NCOORD];
    logic [HP_W-1:0]               hp_s3_reg  [NCOORD];
    logic [oci_pkg::COORD_W-1:0]   lp_s3_next [NCOORD];
    logic [oci_pkg::COORD_W-1:0]   lp_s3_reg  [NCOORD];

    always_comb begin
        logic [oci_pkg::FRAC_W+oci_pkg::COORD_W-1:0] lo_prod;
        for (int i = 0; i < NCOORD; i++) begin
            hp_s3_next[i] = HP_W'(ud_s2_reg[i][UD_W-1:oci_pkg::FRAC_W]) * HP_W'(scale_reg);
            lo_prod = (oci_pkg::FRAC_W+oci_pkg::COORD_W)'(ud_s2_reg[i][oci_pkg::FRAC_W-1:0])
                    * (oci_pkg::FRAC_W+oci_pkg::COORD_W)'(scale_reg);
            // low fraction bits of the small product never reach the cell
            lp_s3_next[i] = lo_prod[oci_pkg::FRAC_W+oci_pkg::COORD_W-1:oci_pkg::FRAC_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end else begin
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        neg_s2_reg <= neg_s2_next;
        ud_s2_reg  <= ud_s2_next;
        neg_s3_reg <= neg_s2_reg;
        hp_s3_reg  <= hp_s3_next;
        lp_s3_reg  <= lp_s3_next;
    end

    // ---------------- stage 4: cells, morton codes, index ----------------
    logic [TREE_LEVELS-1:0] cc [NCOORD];
    logic [NCOORD-1:0]      oor_vec;
    logic                   oor_any;
    logic [CODE_W-1:0]      code_mn, code_mx, code_diff, mx_sh;
    logic [LVL_W-1:0]       shift, level;
    logic [CALC_W-1:0]      offset, index_sum;
    oci_pkg::cell_t         cell_next, cell_reg;
    logic                   done_reg;

    // floor of the Q33.32 product, then range check
    always_comb begin
        logic [SUM_W-1:0] sum;
        logic [C_W-1:0]   c;
        for (int i = 0; i < NCOORD; i++) begin
            sum        = SUM_W'(hp_s3_reg[i]) + SUM_W'(lp_s3_reg[i]);
            c          = sum[SUM_W-1:oci_pkg::FRAC_W];
            oor_vec[i] = neg_s3_reg[i] || (|c[C_W-1:TREE_LEVELS]);
            cc[i]      = c[TREE_LEVELS-1:0];
        end
    end

    assign oor_any = |oor_vec;

    // x in bit 0, y in bit 1, z in bit 2 of each group
    always_comb begin
        for (int b = 0; b < TREE_LEVELS; b++) begin
            code_mn[3*b]   = cc[0][b];
            code_mn[3*b+1] = cc[1][b];
            code_mn[3*b+2] = cc[2][b];
            code_mx[3*b]   = cc[3][b];
            code_mx[3*b+1] = cc[4][b];
            code_mx[3*b+2] = cc[5][b];
        end
    end

    assign code_diff = code_mn ^ code_mx;

    // groups up to and including the highest differing one
    always_comb begin
        shift = '0;
        for (int g = 0; g < TREE_LEVELS; g++) begin
            if (|code_diff[3*g +: 3]) begin
                shift = LVL_W'(g + 1);
            end
        end
    end

    assign level = LVL_W'(TREE_LEVELS) - shift;

    // shift amounts and level offsets are constants per choice of shift
    always_comb begin
        mx_sh  = '0;
        offset = '0;
        for (int k = 0; k <= TREE_LEVELS; k++) begin
            if (shift == LVL_W'(k)) begin
                mx_sh  = CODE_W'(code_mx >> (3 * k));
                offset = CALC_W'(oci_pkg::level_offset(TREE_LEVELS - k));
            end
        end
    end

    assign index_sum = offset + CALC_W'(mx_sh);

    always_comb begin
        if (oor_any) begin
            cell_next.cell_index   = '0;
            cell_next.cell_level   = '0;
            cell_next.out_of_range = 1'b1;
        end else begin
            cell_next.cell_index   = oci_pkg::INDEX_W'(index_sum);
            cell_next.cell_level   = oci_pkg::LEVEL_W'(level);
            cell_next.out_of_range = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        cell_reg <= cell_next;
    end

    assign done   = done_reg;
    assign result = cell_reg;

    // ---------------- checks ----------------
    // a result only ever follows an accepted item
    `OCI_ASSERT_IMPLY(a_done_has_item, clk, rst_n, done, $past(start && !busy, 4))
    // an out-of-range box always reports the root cell
    `OCI_ASSERT_IMPLY(a_oor_root, clk, rst_n, done && result.out_of_range,
        result.cell_index == '0 && result.cell_level == '0)
    // a coordinate below the origin in the product stage flags the result
    `OCI_ASSERT_NEXT(a_neg_flags, clk, rst_n, s3_vld_reg && (|neg_s3_reg),
        done && result.out_of_range)

endmodule
